### src/format_spec_parser_assert.svh
// Assertion macros used by the parser's back stage.
`ifndef FORMAT_SPEC_PARSER_ASSERT_SVH
`define FORMAT_SPEC_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define FSP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define FSP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/fsp_pkg.sv
// Types and constants of the format specification parser.
`default_nettype none

package fsp_pkg;

    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;

    localparam int FLAG_HASH  = 0;
    localparam int FLAG_ZERO  = 1;
    localparam int FLAG_PLUS  = 2;
    localparam int FLAG_MINUS = 3;
    localparam int FLAG_SPACE = 4;

    localparam int TOKQ_DEPTH = 4;
    localparam int RESQ_DEPTH = 2;

    typedef enum logic [2:0] {
        KIND_FLAG,
        KIND_DIGIT,
        KIND_DOT,
        KIND_H,
        KIND_L,
        KIND_J,
        KIND_Z,
        KIND_OTHER
    } fsp_kind_t;

    typedef enum logic [2:0] {
        PH_FLAGS,
        PH_WIDTH,
        PH_PREC,
        PH_LEN_H,
        PH_LEN_L,
        PH_CONV
    } fsp_phase_t;

    typedef enum logic [2:0] {
        LEN_NONE,
        LEN_HH,
        LEN_H,
        LEN_L,
        LEN_LL,
        LEN_J,
        LEN_Z
    } fsp_len_t;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       start_req;
    } fsp_in_t;

    typedef struct packed {
        logic        start;
        logic [7:0]  char_val;
        logic [4:0]  flag_mask;
        logic [3:0]  digit;
        fsp_kind_t   kind;
    } fsp_tok_t;

    typedef struct packed {
        logic        hash_flag;
        logic        zero_flag;
        logic        plus_flag;
        logic        minus_flag;
        logic        space_flag;
        logic        width_given;
        logic [15:0] field_width;
        logic        precision_given;
        logic [15:0] precision_value;
        logic [2:0]  length_code;
        logic [7:0]  conv_char;
        logic [7:0]  spec_length;
    } fsp_out_t;

endpackage

`default_nettype wire

### src/fsp_fifo.sv
// Small first-in first-out queue used for the parser's token and result queues.
`default_nettype none

module fsp_fifo #(
    parameter type item_t = logic [7:0],
    parameter int  DEPTH  = 2
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire item_t wr_data,
    output logic       full,
    input  wire logic  pop,
    output item_t      rd_data,
    output logic       empty
);

    localparam int AW = $clog2(DEPTH);

    item_t          mem_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg;
    logic [AW-1:0]  rd_ptr_reg;
    logic [AW:0]    count_reg;
    logic           do_push;
    logic           do_pop;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

### src/fsp_front.sv
// Front stage: classifies each incoming byte into a parser token.
`default_nettype none

module fsp_front (
    input  wire fsp_pkg::fsp_in_t  item,
    output fsp_pkg::fsp_tok_t      tok
);

    logic [7:0] diff;
    logic       is_digit;

    assign diff     = item.byte_in - fsp_pkg::CH_ZERO;
    assign is_digit = (item.byte_in >= fsp_pkg::CH_ZERO) && (item.byte_in <= fsp_pkg::CH_NINE);

    always_comb
    begin
        tok.start     = item.start_req;
        tok.char_val  = item.byte_in;
        tok.digit     = diff[3:0];
        tok.flag_mask = '0;
        tok.flag_mask[fsp_pkg::FLAG_HASH]  = (item.byte_in == fsp_pkg::CH_HASH);
        tok.flag_mask[fsp_pkg::FLAG_ZERO]  = (item.byte_in == fsp_pkg::CH_ZERO);
        tok.flag_mask[fsp_pkg::FLAG_PLUS]  = (item.byte_in == fsp_pkg::CH_PLUS);
        tok.flag_mask[fsp_pkg::FLAG_MINUS] = (item.byte_in == fsp_pkg::CH_MINUS);
        tok.flag_mask[fsp_pkg::FLAG_SPACE] = (item.byte_in == fsp_pkg::CH_SPACE);

        // A zero is kept as a digit here; the back stage decides by phase.
        priority if (is_digit)
        begin
            tok.kind = fsp_pkg::KIND_DIGIT;
        end
        else if (tok.flag_mask != '0)
        begin
            tok.kind = fsp_pkg::KIND_FLAG;
        end
        else if (item.byte_in == fsp_pkg::CH_DOT)
        begin
            tok.kind = fsp_pkg::KIND_DOT;
        end
        else if (item.byte_in == fsp_pkg::CH_H)
        begin
            tok.kind = fsp_pkg::KIND_H;
        end
        else if (item.byte_in == fsp_pkg::CH_L)
        begin
            tok.kind = fsp_pkg::KIND_L;
        end
        else if (item.byte_in == fsp_pkg::CH_J)
        begin
            tok.kind = fsp_pkg::KIND_J;
        end
        else if (item.byte_in == fsp_pkg::CH_Z)
        begin
            tok.kind = fsp_pkg::KIND_Z;
        end
        else
        begin
            tok.kind = fsp_pkg::KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

### src/fsp_back.sv
// Back stage: parse state machine, decimal accumulation and result build.
`default_nettype none

`include "format_spec_parser_assert.svh"

module fsp_back #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire fsp_pkg::fsp_tok_t  tok,
    input  wire logic               tok_empty,
    output logic                    tok_pop,
    input  wire logic               res_full,
    output logic                    res_push,
    output fsp_pkg::fsp_out_t       res
);

    localparam int AW = VALUE_BITS + 4;
    localparam logic [VALUE_BITS-1:0] MAX_VAL = {VALUE_BITS{1'b1}};

    fsp_pkg::fsp_phase_t    phase_reg, phase_next;
    fsp_pkg::fsp_len_t      len_reg, len_next;
    logic [4:0]             flags_reg, flags_next;
    logic [VALUE_BITS-1:0]  width_reg, width_next;
    logic                   width_seen_reg, width_seen_next;
    logic [VALUE_BITS-1:0]  prec_reg, prec_next;
    logic                   prec_seen_reg, prec_seen_next;
    logic [7:0]             count_reg, count_next;

    logic [VALUE_BITS-1:0]  acc_src;
    logic [AW-1:0]          mac;
    logic [VALUE_BITS-1:0]  acc_sat;
    logic [7:0]             count_inc;
    logic [7:0]             total;
    logic [31:0]            width_ext;
    logic [31:0]            prec_ext;

    assign tok_pop = !tok_empty && !res_full;

    // One shared multiply-by-ten accumulator; a new width starts from zero.
    always_comb
    begin
        unique case (phase_reg)
            fsp_pkg::PH_WIDTH: acc_src = width_reg;
            fsp_pkg::PH_PREC:  acc_src = prec_reg;
            default:           acc_src = '0;
        endcase
        mac     = (AW'(acc_src) << 3) + (AW'(acc_src) << 1) + AW'(tok.digit);
        acc_sat = (mac[AW-1:VALUE_BITS] != '0) ? MAX_VAL : mac[VALUE_BITS-1:0];
    end

    assign count_inc = (count_reg == 8'hFF) ? 8'hFF : count_reg + 8'd1;
    assign total     = (count_inc == 8'hFF) ? 8'hFF : count_inc + 8'd1;
    assign width_ext = 32'(width_reg);
    assign prec_ext  = 32'(prec_reg);

    always_comb
    begin
        res.hash_flag       = flags_reg[fsp_pkg::FLAG_HASH];
        res.zero_flag       = flags_reg[fsp_pkg::FLAG_ZERO];
        res.plus_flag       = flags_reg[fsp_pkg::FLAG_PLUS];
        res.minus_flag      = flags_reg[fsp_pkg::FLAG_MINUS];
        res.space_flag      = flags_reg[fsp_pkg::FLAG_SPACE];
        res.width_given     = width_seen_reg;
        res.field_width     = width_ext[15:0];
        res.precision_given = prec_seen_reg;
        res.precision_value = prec_ext[15:0];
        res.length_code     = len_reg;
        res.conv_char       = tok.char_val;
        res.spec_length     = total;
    end

    always_comb
    begin
        logic emit;
        logic to_len;

        phase_next      = phase_reg;
        len_next        = len_reg;
        flags_next      = flags_reg;
        width_next      = width_reg;
        width_seen_next = width_seen_reg;
        prec_next       = prec_reg;
        prec_seen_next  = prec_seen_reg;
        count_next      = count_reg;
        emit            = 1'b0;
        to_len          = 1'b0;

        if (tok_pop && !tok.start)
        begin
            count_next = count_inc;
            unique case (phase_reg)
                fsp_pkg::PH_FLAGS:
                begin
                    priority if (tok.flag_mask != '0)
                    begin
                        flags_next = flags_reg | tok.flag_mask;
                    end
                    else if (tok.kind == fsp_pkg::KIND_DIGIT)
                    begin
                        width_seen_next = 1'b1;
                        width_next      = acc_sat;
                        phase_next      = fsp_pkg::PH_WIDTH;
                    end
                    else if (tok.kind == fsp_pkg::KIND_DOT)
                    begin
                        prec_seen_next = 1'b1;
                        prec_next      = '0;
                        phase_next     = fsp_pkg::PH_PREC;
                    end
                    else
                    begin
                        to_len = 1'b1;
                    end
                end
                fsp_pkg::PH_WIDTH:
                begin
                    priority if (tok.kind == fsp_pkg::KIND_DIGIT)
                    begin
                        width_next = acc_sat;
                    end
                    else if (tok.kind == fsp_pkg::KIND_DOT)
                    begin
                        prec_seen_next = 1'b1;
                        prec_next      = '0;
                        phase_next     = fsp_pkg::PH_PREC;
                    end
                    else
                    begin
                        to_len = 1'b1;
                    end
                end
                fsp_pkg::PH_PREC:
                begin
                    if (tok.kind == fsp_pkg::KIND_DIGIT)
                    begin
                        prec_next = acc_sat;
                    end
                    else
                    begin
                        to_len = 1'b1;
                    end
                end
                fsp_pkg::PH_LEN_H:
                begin
                    if (tok.kind == fsp_pkg::KIND_H)
                    begin
                        len_next   = fsp_pkg::LEN_HH;
                        phase_next = fsp_pkg::PH_CONV;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                fsp_pkg::PH_LEN_L:
                begin
                    if (tok.kind == fsp_pkg::KIND_L)
                    begin
                        len_next   = fsp_pkg::LEN_LL;
                        phase_next = fsp_pkg::PH_CONV;
                    end
                    else
                    begin
                        emit = 1'b1;
                    end
                end
                default:
                begin
                    emit = 1'b1;
                end
            endcase

            // A byte outside the numeric part opens a length modifier or ends the spec.
            if (to_len)
            begin
                unique case (tok.kind)
                    fsp_pkg::KIND_H:
                    begin
                        len_next   = fsp_pkg::LEN_H;
                        phase_next = fsp_pkg::PH_LEN_H;
                    end
                    fsp_pkg::KIND_L:
                    begin
                        len_next   = fsp_pkg::LEN_L;
                        phase_next = fsp_pkg::PH_LEN_L;
                    end
                    fsp_pkg::KIND_J:
                    begin
                        len_next   = fsp_pkg::LEN_J;
                        phase_next = fsp_pkg::PH_CONV;
                    end
                    fsp_pkg::KIND_Z:
                    begin
                        len_next   = fsp_pkg::LEN_Z;
                        phase_next = fsp_pkg::PH_CONV;
                    end
                    default:
                    begin
                        emit = 1'b1;
                    end
                endcase
            end
        end

        res_push = emit;

        if ((tok_pop && tok.start) || emit)
        begin
            phase_next      = fsp_pkg::PH_FLAGS;
            len_next        = fsp_pkg::LEN_NONE;
            flags_next      = '0;
            width_next      = '0;
            width_seen_next = 1'b0;
            prec_next       = '0;
            prec_seen_next  = 1'b0;
            count_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= fsp_pkg::PH_FLAGS;
            len_reg        <= fsp_pkg::LEN_NONE;
            flags_reg      <= '0;
            width_reg      <= '0;
            width_seen_reg <= 1'b0;
            prec_reg       <= '0;
            prec_seen_reg  <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            phase_reg      <= phase_next;
            len_reg        <= len_next;
            flags_reg      <= flags_next;
            width_reg      <= width_next;
            width_seen_reg <= width_seen_next;
            prec_reg       <= prec_next;
            prec_seen_reg  <= prec_seen_next;
            count_reg      <= count_next;
        end
    end

    `FSP_ASSERT_IMP(a_res_room, res_push, tok_pop && !res_full, "result written without room")
    `FSP_ASSERT_NXT(a_start_clears, tok_pop && tok.start,
        phase_reg == fsp_pkg::PH_FLAGS && count_reg == 8'd0, "start mark did not clear the parse")
    `FSP_ASSERT_IMP(a_prec_phase, prec_seen_reg,
        phase_reg != fsp_pkg::PH_FLAGS && phase_reg != fsp_pkg::PH_WIDTH,
        "precision seen while still in flags or width")
    `FSP_ASSERT_IMP(a_min_length, res_push, res.spec_length >= 8'd2, "result shorter than two bytes")

endmodule

`default_nettype wire

### src/format_spec_parser.sv
// Top level: accepts one specification byte per cycle, while the token queue is not
// full, from a queue-style input. A result passes the token queue, the back stage and
// the result queue on its way out. The back stage takes one byte per cycle while the
// result queue has room; the token and result queues absorb stalls on either side.
// Reset empties both queues and returns the parse to the flags phase.
`default_nettype none

module format_spec_parser #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire fsp_pkg::fsp_in_t  item,
    output logic                   full,
    input  wire logic              pop,
    output fsp_pkg::fsp_out_t      result,
    output logic                   empty
);

    fsp_pkg::fsp_tok_t  tok_in;
    fsp_pkg::fsp_tok_t  tok_out;
    logic               tok_empty;
    logic               tok_pop;
    logic               res_full;
    logic               res_push;
    fsp_pkg::fsp_out_t  res_data;

    fsp_front u_front (
        .item (item),
        .tok  (tok_in)
    );

    fsp_fifo #(
        .item_t (fsp_pkg::fsp_tok_t),
        .DEPTH  (fsp_pkg::TOKQ_DEPTH)
    ) u_tok_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (tok_in),
        .full    (full),
        .pop     (tok_pop),
        .rd_data (tok_out),
        .empty   (tok_empty)
    );

    fsp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .tok       (tok_out),
        .tok_empty (tok_empty),
        .tok_pop   (tok_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res       (res_data)
    );

    fsp_fifo #(
        .item_t (fsp_pkg::fsp_out_t),
        .DEPTH  (fsp_pkg::RESQ_DEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .pop     (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

`default_nettype wire

### tb/tb_format_spec_parser.sv
// Self-checking testbench for the printf conversion specification parser.
`timescale 1ns / 1ps

module tb_format_spec_parser;

    localparam int VALUE_BITS = 16;
    localparam logic [31:0] VALUE_MAX = (32'd1 << VALUE_BITS) - 32'd1;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam int NUM_DIR = 29;
    localparam int HOLD_CYCLES = 80;
    localparam int PHASE_BYTES = 80;

    typedef struct {
        logic [7:0]         ch;
        logic               st;
        bit                 typed;
        fsp_pkg::fsp_out_t  want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               push;
    fsp_pkg::fsp_in_t   in_item;
    logic               full;
    logic               pop;
    fsp_pkg::fsp_out_t  out_spec;
    logic               empty;

    // Parse state mirrored from the block.
    fsp_pkg::fsp_phase_t ps_phase;
    logic [4:0]          ps_flags;
    logic [31:0]         ps_width;
    logic                ps_width_on;
    logic [31:0]         ps_prec;
    logic                ps_prec_on;
    fsp_pkg::fsp_len_t   ps_len;
    int unsigned         ps_count;

    fsp_pkg::fsp_out_t pending_specs[$];
    dir_row_t dir_rows [NUM_DIR];

    int mismatches = 0;
    int bytes_sent = 0;
    int starts_sent = 0;
    int specs_checked = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_asks = 0;

    format_spec_parser #(
        .VALUE_BITS(VALUE_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .item  (in_item),
        .full  (full),
        .pop   (pop),
        .result(out_spec),
        .empty (empty)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void clear_parse_state();
        ps_phase    = fsp_pkg::PH_FLAGS;
        ps_flags    = '0;
        ps_width    = '0;
        ps_width_on = 1'b0;
        ps_prec     = '0;
        ps_prec_on  = 1'b0;
        ps_len      = fsp_pkg::LEN_NONE;
        ps_count    = 0;
    endfunction

    function automatic logic [31:0] sat_accum(input logic [31:0] acc, input logic [7:0] ch);
        logic [31:0] v;
        v = acc * 32'd10 + 32'(ch - fsp_pkg::CH_ZERO);
        return (v > VALUE_MAX) ? VALUE_MAX : v;
    endfunction

    function automatic fsp_pkg::fsp_out_t close_spec(input logic [7:0] conv);
        fsp_pkg::fsp_out_t s;
        s.hash_flag       = ps_flags[fsp_pkg::FLAG_HASH];
        s.zero_flag       = ps_flags[fsp_pkg::FLAG_ZERO];
        s.plus_flag       = ps_flags[fsp_pkg::FLAG_PLUS];
        s.minus_flag      = ps_flags[fsp_pkg::FLAG_MINUS];
        s.space_flag      = ps_flags[fsp_pkg::FLAG_SPACE];
        s.width_given     = ps_width_on;
        s.field_width     = ps_width[15:0];
        s.precision_given = ps_prec_on;
        s.precision_value = ps_prec[15:0];
        s.length_code     = ps_len;
        s.conv_char       = conv;
        s.spec_length     = (ps_count + 1 > 255) ? 8'd255 : 8'(ps_count + 1);
        clear_parse_state();
        return s;
    endfunction

    // A byte past the flags, width and precision: a length letter or the conversion.
    function automatic bit length_or_conv(input logic [7:0] ch,
                                          output fsp_pkg::fsp_out_t s);
        s = '0;
        case (ch)
            fsp_pkg::CH_H:
            begin
                ps_len = fsp_pkg::LEN_H;
                ps_phase = fsp_pkg::PH_LEN_H;
            end
            fsp_pkg::CH_L:
            begin
                ps_len = fsp_pkg::LEN_L;
                ps_phase = fsp_pkg::PH_LEN_L;
            end
            fsp_pkg::CH_J:
            begin
                ps_len = fsp_pkg::LEN_J;
                ps_phase = fsp_pkg::PH_CONV;
            end
            fsp_pkg::CH_Z:
            begin
                ps_len = fsp_pkg::LEN_Z;
                ps_phase = fsp_pkg::PH_CONV;
            end
            default:
            begin
                s = close_spec(ch);
                return 1'b1;
            end
        endcase
        return 1'b0;
    endfunction

    function automatic bit predict_spec(input logic [7:0] ch, input logic st,
                                        output fsp_pkg::fsp_out_t s);
        bit is_digit;
        is_digit = (ch >= fsp_pkg::CH_ZERO) && (ch <= fsp_pkg::CH_NINE);
        s = '0;
        if (st)
        begin
            clear_parse_state();
            return 1'b0;
        end
        if (ps_count < 255)
            ps_count++;
        case (ps_phase)
            fsp_pkg::PH_FLAGS:
            begin
                case (ch)
                    fsp_pkg::CH_HASH:  ps_flags[fsp_pkg::FLAG_HASH] = 1'b1;
                    fsp_pkg::CH_ZERO:  ps_flags[fsp_pkg::FLAG_ZERO] = 1'b1;
                    fsp_pkg::CH_PLUS:  ps_flags[fsp_pkg::FLAG_PLUS] = 1'b1;
                    fsp_pkg::CH_MINUS: ps_flags[fsp_pkg::FLAG_MINUS] = 1'b1;
                    fsp_pkg::CH_SPACE: ps_flags[fsp_pkg::FLAG_SPACE] = 1'b1;
                    fsp_pkg::CH_DOT:
                    begin
                        ps_prec_on = 1'b1;
                        ps_prec = '0;
                        ps_phase = fsp_pkg::PH_PREC;
                    end
                    default:
                    begin
                        if (!is_digit)
                            return length_or_conv(ch, s);
                        ps_width_on = 1'b1;
                        ps_width = sat_accum('0, ch);
                        ps_phase = fsp_pkg::PH_WIDTH;
                    end
                endcase
                return 1'b0;
            end
            fsp_pkg::PH_WIDTH:
            begin
                if (is_digit)
                    ps_width = sat_accum(ps_width, ch);
                else if (ch == fsp_pkg::CH_DOT)
                begin
                    ps_prec_on = 1'b1;
                    ps_prec = '0;
                    ps_phase = fsp_pkg::PH_PREC;
                end
                else
                    return length_or_conv(ch, s);
                return 1'b0;
            end
            fsp_pkg::PH_PREC:
            begin
                if (!is_digit)
                    return length_or_conv(ch, s);
                ps_prec = sat_accum(ps_prec, ch);
                return 1'b0;
            end
            fsp_pkg::PH_LEN_H:
            begin
                if (ch != fsp_pkg::CH_H)
                begin
                    s = close_spec(ch);
                    return 1'b1;
                end
                ps_len = fsp_pkg::LEN_HH;
                ps_phase = fsp_pkg::PH_CONV;
                return 1'b0;
            end
            fsp_pkg::PH_LEN_L:
            begin
                if (ch != fsp_pkg::CH_L)
                begin
                    s = close_spec(ch);
                    return 1'b1;
                end
                ps_len = fsp_pkg::LEN_LL;
                ps_phase = fsp_pkg::PH_CONV;
                return 1'b0;
            end
            default:
            begin
                s = close_spec(ch);
                return 1'b1;
            end
        endcase
    endfunction

    function automatic fsp_pkg::fsp_out_t spec_of(input logic [4:0] flags, input logic wg,
                                                  input logic [15:0] w, input logic pg,
                                                  input logic [15:0] p,
                                                  input fsp_pkg::fsp_len_t len,
                                                  input logic [7:0] conv,
                                                  input logic [7:0] slen);
        fsp_pkg::fsp_out_t s;
        s.hash_flag       = flags[fsp_pkg::FLAG_HASH];
        s.zero_flag       = flags[fsp_pkg::FLAG_ZERO];
        s.plus_flag       = flags[fsp_pkg::FLAG_PLUS];
        s.minus_flag      = flags[fsp_pkg::FLAG_MINUS];
        s.space_flag      = flags[fsp_pkg::FLAG_SPACE];
        s.width_given     = wg;
        s.field_width     = w;
        s.precision_given = pg;
        s.precision_value = p;
        s.length_code     = len;
        s.conv_char       = conv;
        s.spec_length     = slen;
        return s;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_spec(input fsp_pkg::fsp_out_t got);
        fsp_pkg::fsp_out_t want;
        if (pending_specs.size() == 0)
        begin
            $error("result transaction with no specification outstanding (conv_char %0d)",
                   got.conv_char);
            mismatches++;
            return;
        end
        want = pending_specs.pop_front();
        check_field("hash_flag", 16'(want.hash_flag), 16'(got.hash_flag));
        check_field("zero_flag", 16'(want.zero_flag), 16'(got.zero_flag));
        check_field("plus_flag", 16'(want.plus_flag), 16'(got.plus_flag));
        check_field("minus_flag", 16'(want.minus_flag), 16'(got.minus_flag));
        check_field("space_flag", 16'(want.space_flag), 16'(got.space_flag));
        check_field("width_given", 16'(want.width_given), 16'(got.width_given));
        check_field("field_width", want.field_width, got.field_width);
        check_field("precision_given", 16'(want.precision_given), 16'(got.precision_given));
        check_field("precision_value", want.precision_value, got.precision_value);
        check_field("length_code", 16'(want.length_code), 16'(got.length_code));
        check_field("conv_char", 16'(want.conv_char), 16'(got.conv_char));
        check_field("spec_length", 16'(want.spec_length), 16'(got.spec_length));
        specs_checked++;
    endtask

    // Called at a rising edge; returns at the rising edge that takes the transaction.
    task automatic send_item(input logic [7:0] ch, input logic st, input bit typed,
                             input fsp_pkg::fsp_out_t want);
        fsp_pkg::fsp_out_t predicted;
        bit got;
        bit taken;
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        in_item <= '{byte_in: ch, start_req: st};
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
        end
        got = predict_spec(ch, st, predicted);
        if (typed)
            pending_specs.push_back(want);
        else if (got)
            pending_specs.push_back(predicted);
        if (st)
            starts_sent++;
        else
            bytes_sent++;
    endtask

    task automatic send_byte(input logic [7:0] ch, input logic st);
        send_item(ch, st, 1'b0, '0);
    endtask

    task automatic wait_for_drain();
        push <= 1'b0;
        while (pending_specs.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    function automatic logic [7:0] random_digit(input bit nonzero);
        return fsp_pkg::CH_ZERO + 8'($urandom_range(nonzero ? 1 : 0, 9));
    endfunction

    function automatic int random_count();
        // Long digit runs now and then, so that the accumulators saturate.
        return ($urandom_range(9) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 3);
    endfunction

    task automatic send_wellformed_spec();
        logic [7:0] flag_chars [5];
        logic [7:0] conv_chars [8];
        int n;
        flag_chars = '{fsp_pkg::CH_HASH, fsp_pkg::CH_ZERO, fsp_pkg::CH_PLUS,
                       fsp_pkg::CH_MINUS, fsp_pkg::CH_SPACE};
        conv_chars = '{8'h64, 8'h69, 8'h75, 8'h78, 8'h58, 8'h73, 8'h66, CH_PERCENT};
        if ($urandom_range(99) < 85)
            send_byte(($urandom_range(3) == 0) ? 8'($urandom) : CH_PERCENT, 1'b1);
        n = $urandom_range(0, 3);
        repeat (n) send_byte(flag_chars[$urandom_range(4)], 1'b0);
        n = random_count();
        for (int i = 0; i < n; i++)
            send_byte(random_digit(i == 0), 1'b0);
        if ($urandom_range(1))
        begin
            send_byte(fsp_pkg::CH_DOT, 1'b0);
            n = random_count();
            repeat (n) send_byte(random_digit(1'b0), 1'b0);
        end
        case ($urandom_range(6))
            1: begin send_byte(fsp_pkg::CH_H, 1'b0); send_byte(fsp_pkg::CH_H, 1'b0); end
            2: send_byte(fsp_pkg::CH_H, 1'b0);
            3: send_byte(fsp_pkg::CH_L, 1'b0);
            4: begin send_byte(fsp_pkg::CH_L, 1'b0); send_byte(fsp_pkg::CH_L, 1'b0); end
            5: send_byte(fsp_pkg::CH_J, 1'b0);
            6: send_byte(fsp_pkg::CH_Z, 1'b0);
            default: ;
        endcase
        if ($urandom_range(99) < 70)
            send_byte(conv_chars[$urandom_range(7)], 1'b0);
        else
            send_byte(8'($urandom), 1'b0);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 8);
        repeat (n) send_byte(8'($urandom), ($urandom_range(9) == 0));
    endtask

    // Result side: pop decided at the rising edge, transaction sampled mid-cycle.
    initial
    begin : result_side
        int hold_served;
        int hold_left;
        hold_served = 0;
        hold_left = 0;
        pop <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_served)
            begin
                hold_served = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
            @(negedge clk);
            if (pop && !empty)
                check_spec(out_spec);
        end
    end

    initial
    begin
        #1000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        push <= 1'b0;
        in_item <= '0;
        clear_parse_state();

        dir_rows = '{
            '{8'h00, 1'b0, 1'b1,
              spec_of(5'b00000, 1'b0, 16'd0, 1'b0, 16'd0, fsp_pkg::LEN_NONE,
                      8'h00, 8'd2)},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{fsp_pkg::CH_HASH, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_PLUS, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_MINUS, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_SPACE, 1'b0, 1'b0, '0},
            '{8'h78, 1'b0, 1'b1,
              spec_of(5'b11111, 1'b0, 16'd0, 1'b0, 16'd0, fsp_pkg::LEN_NONE,
                      8'h78, 8'd7)},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{8'h31, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_ZERO, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_DOT, 1'b0, 1'b0, '0},
            '{8'h35, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_L, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_L, 1'b0, 1'b0, '0},
            '{8'h75, 1'b0, 1'b0, '0},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{fsp_pkg::CH_DOT, 1'b0, 1'b0, '0},
            '{fsp_pkg::CH_PLUS, 1'b0, 1'b1,
              spec_of(5'b00000, 1'b0, 16'd0, 1'b1, 16'd0, fsp_pkg::LEN_NONE,
                      fsp_pkg::CH_PLUS, 8'd3)},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{fsp_pkg::CH_H, 1'b0, 1'b0, '0},
            '{8'h64, 1'b0, 1'b1,
              spec_of(5'b00000, 1'b0, 16'd0, 1'b0, 16'd0, fsp_pkg::LEN_H,
                      8'h64, 8'd3)},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{8'h35, 1'b0, 1'b0, '0},
            '{CH_PERCENT, 1'b1, 1'b0, '0},
            '{fsp_pkg::CH_Z, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b1,
              spec_of(5'b00000, 1'b0, 16'd0, 1'b0, 16'd0, fsp_pkg::LEN_Z,
                      8'hFF, 8'd3)},
            '{fsp_pkg::CH_J, 1'b0, 1'b0, '0},
            '{8'h64, 1'b0, 1'b1,
              spec_of(5'b00000, 1'b0, 16'd0, 1'b0, 16'd0, fsp_pkg::LEN_J,
                      8'h64, 8'd3)}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
            send_item(dir_rows[i].ch, dir_rows[i].st, dir_rows[i].typed, dir_rows[i].want);
        wait_for_drain();

        for (int ph = 0; ph < 4; ph++)
        begin
            int phase_start;
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            // The first phase opens with a long receiver hold-off so that the block backs up.
            if (ph == 0)
                hold_asks++;
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES)
            begin
                if ($urandom_range(99) < 12)
                    send_noise();
                else
                    send_wellformed_spec();
            end
            wait_for_drain();
        end

        $display("tb: %0d bytes and %0d start marks sent, %0d specifications checked",
                 bytes_sent, starts_sent, specs_checked);
        $display("tb: idling phases covered none, sender, receiver and both, with one hold-off");
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
